FILE: rtl/dsc_pkg.sv
// Shared types, codes and match tables for the page splitter.
`default_nettype none

package dsc_pkg;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_HEADER     = 4'd0,
    PH_HDR_SKIP   = 4'd1,
    PH_LINE_START = 4'd2,
    PH_COPY       = 4'd3,
    PH_PCT1       = 4'd4,
    PH_PCT2       = 4'd5,
    PH_MATCH_P    = 4'd6,
    PH_MATCH_T    = 4'd7,
    PH_SKIP       = 4'd8,
    PH_DONE       = 4'd9,
    PH_ERROR      = 4'd10
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_PAGE    = 2'd1;
  localparam logic [1:0] KIND_TRAILER = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Characters that steer the parser.
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_UPPER_P = 8'h50;
  localparam logic [7:0] CH_UPPER_T = 8'h54;

  // Lengths of the three match strings.
  localparam logic [3:0] HDR_LEN   = 4'd11;
  localparam logic [3:0] PAGE_LEN  = 4'd4;
  localparam logic [3:0] TRAIL_LEN = 4'd6;

  // One result leaving the parser.
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic       prologue;
  } res_t;

  // Parser status seen by the top level.
  typedef struct packed {
    logic done;
    logic failed;
  } stat_t;

  // "%!PS-Adobe-"
  function automatic logic [7:0] hdr_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h25;
      4'd1:    c = 8'h21;
      4'd2:    c = 8'h50;
      4'd3:    c = 8'h53;
      4'd4:    c = 8'h2D;
      4'd5:    c = 8'h41;
      4'd6:    c = 8'h64;
      4'd7:    c = 8'h6F;
      4'd8:    c = 8'h62;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h2D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "age:" (the leading 'P' is checked on its own)
  function automatic logic [7:0] page_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h61;
      4'd1:    c = 8'h67;
      4'd2:    c = 8'h65;
      4'd3:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "railer" (the leading 'T' is checked on its own)
  function automatic logic [7:0] trail_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h72;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h69;
      4'd3:    c = 8'h6C;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dsc_parser.sv
// Parser state machine: holds the stream state and forms at most one result per byte.
`default_nettype none

module dsc_parser
  import dsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] byte_in,
  input  wire logic       eof,
  output res_t            res,
  output stat_t           stat
);

  phase_t     phase, phase_next;
  logic [3:0] match_pos, match_pos_next;
  logic       prologue, prologue_next;
  logic       seg_matched, seg_matched_next;
  logic       trl_matched, trl_matched_next;

  logic live;
  logic active;
  logic hdr_miss;
  logic page_miss;
  logic trail_miss;

  // The result depends only on the held byte, its end-of-file flag and the state,
  // so the caller can decide from it whether the byte may step the state.
  assign live       = (phase != PH_DONE) && (phase != PH_ERROR);
  assign active     = step && live;
  assign hdr_miss   = (match_pos >= HDR_LEN) || (byte_in != hdr_char(match_pos));
  assign page_miss  = (match_pos >= PAGE_LEN) || (byte_in != page_char(match_pos));
  assign trail_miss = (match_pos >= TRAIL_LEN) || (byte_in != trail_char(match_pos));

  // Next state.
  always_comb begin
    phase_next       = phase;
    match_pos_next   = match_pos;
    prologue_next    = prologue;
    seg_matched_next = seg_matched;
    trl_matched_next = trl_matched;
    if (active) begin
      if (eof) begin
        phase_next = PH_ERROR;
      end else begin
        unique case (phase)
          PH_HEADER: begin
            if (hdr_miss) begin
              phase_next = PH_ERROR;
            end else if (match_pos == HDR_LEN - 4'd1) begin
              match_pos_next = 4'd0;
              phase_next     = PH_HDR_SKIP;
            end else begin
              match_pos_next = match_pos + 4'd1;
            end
          end
          PH_HDR_SKIP: begin
            if (byte_in == CH_LF) phase_next = PH_LINE_START;
          end
          PH_LINE_START: begin
            if (byte_in == CH_PERCENT) phase_next = PH_PCT1;
            else if (byte_in == CH_LF) phase_next = PH_LINE_START;
            else phase_next = PH_COPY;
          end
          PH_COPY: begin
            if (byte_in == CH_LF) phase_next = PH_LINE_START;
          end
          PH_PCT1: begin
            phase_next = (byte_in == CH_PERCENT) ? PH_PCT2 : PH_SKIP;
          end
          PH_PCT2: begin
            match_pos_next = 4'd0;
            if (byte_in == CH_UPPER_P) phase_next = PH_MATCH_P;
            else if (byte_in == CH_UPPER_T) phase_next = PH_MATCH_T;
            else phase_next = PH_SKIP;
          end
          PH_MATCH_P: begin
            if (page_miss) begin
              match_pos_next = 4'd0;
              phase_next     = PH_SKIP;
            end else if (match_pos == PAGE_LEN - 4'd1) begin
              match_pos_next   = 4'd0;
              seg_matched_next = 1'b1;
              phase_next       = PH_SKIP;
            end else begin
              match_pos_next = match_pos + 4'd1;
            end
          end
          PH_MATCH_T: begin
            if (trail_miss) begin
              match_pos_next = 4'd0;
              phase_next     = PH_SKIP;
            end else if (match_pos == TRAIL_LEN - 4'd1) begin
              match_pos_next = 4'd0;
              if (prologue) begin
                phase_next = PH_ERROR;
              end else begin
                seg_matched_next = 1'b1;
                trl_matched_next = 1'b1;
                phase_next       = PH_SKIP;
              end
            end else begin
              match_pos_next = match_pos + 4'd1;
            end
          end
          PH_SKIP: begin
            if (byte_in == CH_LF) begin
              if (seg_matched) begin
                prologue_next    = 1'b0;
                seg_matched_next = 1'b0;
                phase_next       = trl_matched ? PH_DONE : PH_LINE_START;
              end else begin
                phase_next = PH_LINE_START;
              end
            end
          end
          default: phase_next = PH_ERROR;
        endcase
      end
    end
  end

  // Result for the current byte.
  always_comb begin
    res          = '0;
    res.prologue = prologue;
    if (live) begin
      if (eof) begin
        res.valid = 1'b1;
        res.kind  = KIND_ERROR;
      end else begin
        unique case (phase)
          PH_HEADER: begin
            if (hdr_miss) begin
              res.valid = 1'b1;
              res.kind  = KIND_ERROR;
            end
          end
          PH_LINE_START: begin
            if (byte_in != CH_PERCENT) begin
              res.valid = 1'b1;
              res.kind  = KIND_BYTE;
              res.data  = byte_in;
            end
          end
          PH_COPY: begin
            res.valid = 1'b1;
            res.kind  = KIND_BYTE;
            res.data  = byte_in;
          end
          PH_MATCH_T: begin
            if (!trail_miss && match_pos == TRAIL_LEN - 4'd1 && prologue) begin
              res.valid = 1'b1;
              res.kind  = KIND_ERROR;
            end
          end
          PH_SKIP: begin
            if (byte_in == CH_LF && seg_matched) begin
              res.valid = 1'b1;
              res.kind  = trl_matched ? KIND_TRAILER : KIND_PAGE;
            end
          end
          default: res.valid = 1'b0;
        endcase
      end
    end
  end

  assign stat.done   = (phase == PH_DONE);
  assign stat.failed = (phase == PH_ERROR);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      match_pos   <= 4'd0;
      prologue    <= 1'b1;
      seg_matched <= 1'b0;
      trl_matched <= 1'b0;
    end else begin
      phase       <= phase_next;
      match_pos   <= match_pos_next;
      prologue    <= prologue_next;
      seg_matched <= seg_matched_next;
      trl_matched <= trl_matched_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dsc_result_reg.sv
// Output register that holds one result until the consumer takes it.
`default_nettype none

module dsc_result_reg
  import dsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  res_t            res,
  output logic            load_ok,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      result_kind,
  output logic [7:0]      out_byte,
  output logic            was_prologue
);

  // The register can load whenever it is empty or being emptied this cycle.
  assign load_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && res.valid) begin
      result_kind  <= res.kind;
      out_byte     <= res.data;
      was_prologue <= res.prologue;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dsc_page_splitter_core.sv
// Top level of the page splitter: input register, parser and result register.
`default_nettype none

// Channel  Handshake             Payload
// -------  --------------------  -----------------------------------------
// input    in_valid / in_ready   in_byte[7:0], end_of_file
// output   out_valid / out_ready result_kind[1:0], out_byte[7:0], was_prologue
//
// One byte is taken per cycle while the input register is free or moving on.
// An accepted item sits in the input register, where the parser state machine
// decides on it, and its result, if any, lands in the result register on the
// edge at which the item leaves; out_valid rises with that load. Reset clears
// the valid flags and puts the parser back at the header check. A stall on the
// output only holds the input register while it carries an item that produces
// a result; bytes that are dropped keep flowing while a result waits to be
// taken.

module dsc_page_splitter_core
  import dsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_file,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      result_kind,
  output logic [7:0]      out_byte,
  output logic            was_prologue
);

  // Input register.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_eof;

  res_t  res;
  stat_t stat;
  logic  load_ok;
  logic  advance;

  // The held item moves on when its result, if it has one, can be stored.
  assign advance  = hold_valid && (!res.valid || load_ok);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= in_byte;
      hold_eof  <= end_of_file;
    end
  end

  // The parser state steps at most once per item, when the item leaves.
  dsc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (hold_byte),
    .eof     (hold_eof),
    .res     (res),
    .stat    (stat)
  );

  res_t res_gated;

  // Only results of items that actually advance are stored.
  always_comb begin
    res_gated       = res;
    res_gated.valid = res.valid && advance;
  end

  dsc_result_reg u_result (
    .clk          (clk),
    .rst          (rst),
    .res          (res_gated),
    .load_ok      (load_ok),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .out_byte     (out_byte),
    .was_prologue (was_prologue)
  );

  // A format error is the last result ever produced.
  a_error_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_ERROR) |=> (!out_valid || result_kind == KIND_ERROR))
    else $error("result after a format error");

  // Only copied bytes carry data.
  a_byte_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != KIND_BYTE) |-> (out_byte == 8'd0))
    else $error("nonzero byte on a non-byte result");

  // A finished or failed parser forms no results.
  a_quiet_end : assert property (@(posedge clk) disable iff (rst)
    (stat.done || stat.failed) |-> !res.valid)
    else $error("result formed after end of stream");

  // A trailer never closes the prologue.
  a_trailer_not_prologue : assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_TRAILER) |-> !was_prologue)
    else $error("trailer reported inside the prologue");

endmodule

`default_nettype wire
